// ----- design/maf_pkg.sv -----
package maf_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_COUNT_W = 11;
   localparam int ADDR_W        = 32;
   localparam int FUNC_W        = 2;
   localparam int STATUS_W      = 2;

   localparam logic [ADDR_W-1:0] FREE_MARK = 32'hffff_ffff;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] address;
   } maf_request_type;

   typedef struct packed {
      logic                     drop;
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } maf_result_type;

   typedef struct packed {
      logic addr_match;
      logic equal;
      logic free;
   } maf_match_type;

endpackage

// ----- design/maf_compare.sv -----
module maf_compare
   import maf_pkg::*;
(
   input  logic [ADDR_W-1:0] address,
   input  logic [ADDR_W-1:0] pattern,
   output maf_match_type     flags
);

   logic [ADDR_W-1:0] octet_mask;

   // An octet of the pattern that is zero is a wildcard.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         octet_mask[8*k +: 8] = (pattern[8*k +: 8] != 8'h00) ? 8'hff : 8'h00;
      end
   end

   assign flags.addr_match = ((address & octet_mask) == pattern);
   assign flags.equal      = (address == pattern);
   assign flags.free       = (pattern == FREE_MARK);

endmodule

// ----- design/maf_engine.sv -----
module maf_engine
   import maf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  maf_request_type request,
   input  logic            drop_on_match,
   input  logic            result_taken,
   output logic            idle,
   output logic            result_valid,
   output maf_result_type  result
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]    data_idx_ff, data_idx_in;
   logic                drop_ff, drop_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   rd_data_ff;

   logic [ADDR_W-1:0] pattern_mem [TABLE_DEPTH];

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ADDR_W-1:0] wr_data;
   logic              issue;
   logic              hit;
   logic [CNT_W-1:0]  next_idx;
   maf_match_type     flags;

   maf_compare u_compare (
      .address (addr_ff),
      .pattern (rd_data_ff),
      .flags   (flags)
   );

   always_comb begin
      unique case (func_ff)
         FUNC_LOOKUP: hit = flags.addr_match;
         FUNC_ADD:    hit = flags.free;
         FUNC_REMOVE: hit = flags.equal;
         default:     hit = 1'b0;
      endcase
   end

   assign issue    = (rd_idx_ff < count_ff);
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign next_idx = CNT_W'(data_idx_ff) + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      data_vld_in = data_vld_ff;
      data_idx_in = data_idx_ff;
      drop_in     = drop_ff;
      status_in   = status_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = data_idx_ff;
      wr_data     = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in     = request.func;
               addr_in     = request.address;
               drop_in     = 1'b0;
               status_in   = STATUS_DONE;
               rd_idx_in   = '0;
               data_vld_in = 1'b0;
               state_in    = (request.func == FUNC_NONE) ? S_DONE : S_SCAN;
            end
         end

         S_SCAN: begin
            // One entry is read per cycle; its word is compared from the read register.
            if (issue) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               data_vld_in = 1'b1;
               data_idx_in = rd_idx_ff[IDX_W-1:0];
            end else begin
               data_vld_in = 1'b0;
            end

            if (data_vld_ff && hit) begin
               data_vld_in = 1'b0;
               state_in    = S_DONE;
               unique case (func_ff)
                  FUNC_LOOKUP: drop_in = drop_on_match;
                  FUNC_ADD:    wr_en   = 1'b1;
                  FUNC_REMOVE: begin
                     if (next_idx < count_ff) begin
                        rd_idx_in = next_idx;
                        state_in  = S_SHIFT;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: ;
               endcase
            end else if (!data_vld_ff && !issue) begin
               state_in = S_DONE;
               unique case (func_ff)
                  FUNC_LOOKUP: drop_in = ~drop_on_match;
                  FUNC_ADD: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        status_in = STATUS_FULL;
                     end
                  end
                  FUNC_REMOVE: status_in = STATUS_NOT_FOUND;
                  default: ;
               endcase
            end
         end

         S_SHIFT: begin
            // Each later entry moves down by one place.
            if (issue) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               data_vld_in = 1'b1;
               data_idx_in = rd_idx_ff[IDX_W-1:0];
            end else begin
               data_vld_in = 1'b0;
            end

            if (data_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = data_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end else if (!issue) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (result_taken) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pattern_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         data_vld_ff <= data_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      drop_ff     <= drop_in;
      status_ff   <= status_in;
   end

   assign idle               = (state_ff == S_IDLE);
   assign result_valid       = (state_ff == S_DONE);
   assign result.drop        = drop_ff;
   assign result.status      = status_ff;
   assign result.entry_count = ENTRY_COUNT_W'(count_ff);

endmodule

// ----- design/masked_address_filter_table.sv -----
// Channel   Direction  Handshake                   Contents
// req_      in         req_tvalid / req_tready     func, address
// rsp_      out        rsp_tvalid / rsp_tready     drop, status, entry_count
// csr_      in         csr_valid / csr_ready       drop_on_match
//
// Every word is handled by one sequencer around the single read port of the
// pattern memory, which reads one entry per cycle. With n entries in use, a lookup
// or add that finds nothing reads all n entries before its result shows; a hit at
// entry i ends the scan there. A remove that hits moves any later entries down by
// one place. The engine returns to idle after each result before the next word is
// taken, and a full output register holds the engine.
// Reset clears the entry count and sets drop_on_match; the pattern memory is not cleared.
// A stalled result sits in the output register while the next word is taken.
module masked_address_filter_table
   import maf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // func [1:0], address [33:2], zero [39:34]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drop [0], status [2:1], entry_count [13:3], zero [15:14]

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic            drop_on_match_ff, drop_on_match_in;
   logic            rsp_valid_ff, rsp_valid_in;
   maf_result_type  rsp_data_ff, rsp_data_in;
   maf_request_type request;
   maf_result_type  result;
   logic            engine_idle;
   logic            result_valid;
   logic            result_taken;
   logic            start;

   assign request.func    = req_tdata[FUNC_W-1:0];
   assign request.address = req_tdata[FUNC_W +: ADDR_W];
   assign start           = req_tvalid && req_tready;
   assign req_tready      = engine_idle;

   maf_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .request       (request),
      .drop_on_match (drop_on_match_ff),
      .result_taken  (result_taken),
      .idle          (engine_idle),
      .result_valid  (result_valid),
      .result        (result)
   );

   assign csr_ready        = 1'b1;
   assign drop_on_match_in = (csr_valid && csr_ready) ? csr_data : drop_on_match_ff;

   assign result_taken = result_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_on_match_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         drop_on_match_ff <= drop_on_match_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.entry_count, rsp_data_ff.status,
                        rsp_data_ff.drop};

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:3] <= ENTRY_COUNT_W'(TABLE_DEPTH)))
      else $error("entry count beyond table depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:1] == STATUS_FULL)
         |-> (rsp_tdata[13:3] == ENTRY_COUNT_W'(TABLE_DEPTH)))
      else $error("table full reported below depth");

   a_drop_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[2:1] == STATUS_DONE))
      else $error("drop set on a failed operation");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new word taken while the engine works");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import maf_pkg::*;

   localparam int CYCLE_LIMIT = 10_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // func [1:0], address [33:2], zero [39:34]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // drop [0], status [2:1], entry_count [13:3], zero [15:14]

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   masked_address_filter_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Shadow of the filter table, kept in step with accepted words.
   logic [ADDR_W-1:0] acl_patterns [TABLE_DEPTH];
   int                acl_used = 0;
   logic              acl_drop_on_match = 1'b1;

   maf_request_type   requests_waiting [$];
   maf_result_type    verdicts_due [$];
   int                requests_sent = 0;
   int                requests_taken = 0;
   int                results_checked = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   logic              req_fire = 1'b0;

   function automatic maf_result_type filter_predict(input logic [FUNC_W-1:0] func,
                                                     input logic [ADDR_W-1:0] address);
      maf_result_type    r;
      logic [ADDR_W-1:0] mask;
      int                i;
      int                k;
      int                slot;
      logic              hit;
      r = '0;
      case (func)
         FUNC_LOOKUP: begin
            hit = 1'b0;
            for (i = 0; i < acl_used; i++) begin
               for (k = 0; k < 4; k++) begin
                  mask[8*k +: 8] = (acl_patterns[i][8*k +: 8] != 8'd0) ? 8'hff : 8'h00;
               end
               if ((address & mask) == acl_patterns[i]) hit = 1'b1;
            end
            r.drop = hit ? acl_drop_on_match : ~acl_drop_on_match;
         end
         FUNC_ADD: begin
            // Scanning downward leaves the lowest all-ones entry in slot.
            slot = acl_used;
            for (i = acl_used - 1; i >= 0; i--) begin
               if (acl_patterns[i] == FREE_MARK) slot = i;
            end
            if (slot == TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               acl_patterns[slot] = address;
               if (slot == acl_used) acl_used++;
            end
         end
         FUNC_REMOVE: begin
            slot = -1;
            for (i = acl_used - 1; i >= 0; i--) begin
               if (acl_patterns[i] == address) slot = i;
            end
            if (slot < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               for (i = slot + 1; i < acl_used; i++) acl_patterns[i-1] = acl_patterns[i];
               acl_used--;
            end
         end
         default: begin
         end
      endcase
      r.entry_count = acl_used[ENTRY_COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] random_pattern();
      logic [ADDR_W-1:0] p;
      int                k;
      for (k = 0; k < 4; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: p[8*k +: 8] = 8'd0;
            3:       p[8*k +: 8] = 8'd255;
            4:       p[8*k +: 8] = 8'd10;
            5:       p[8*k +: 8] = 8'd192;
            default: p[8*k +: 8] = 8'($urandom_range(1, 255));
         endcase
      end
      return p;
   endfunction

   task automatic offer(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] address);
      maf_request_type word;
      word.func = func;
      word.address = address;
      while (requests_waiting.size() > 1) @(posedge clock);
      requests_waiting.push_back(word);
      requests_sent++;
   endtask

   // Mostly well-formed traffic: lookups aimed at stored patterns and removes of
   // patterns that are present. The add share shrinks as the table grows so
   // that scans stay short.
   task automatic offer_random_request();
      int                roll;
      int                add_cut;
      int                k;
      int                bit_pos;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] seed;
      logic [FUNC_W-1:0] func;
      roll = $urandom_range(0, 99);
      add_cut = (acl_used < 6) ? 55 : ((acl_used > 40) ? 12 : 30);
      addr = random_pattern();
      if (roll < 5) begin
         func = FUNC_NONE;
         addr = $urandom();
      end else if (roll < add_cut) begin
         func = FUNC_ADD;
         roll = $urandom_range(0, 99);
         if (roll < 8) addr = FREE_MARK;
         else if (roll < 18 && acl_used > 0) addr = acl_patterns[$urandom_range(0, acl_used - 1)];
         else if (roll < 23) addr = $urandom();
      end else if (roll < add_cut + 25) begin
         func = FUNC_REMOVE;
         roll = $urandom_range(0, 99);
         if (roll < 65 && acl_used > 0) addr = acl_patterns[$urandom_range(0, acl_used - 1)];
         else if (roll < 75) addr = FREE_MARK;
      end else begin
         func = FUNC_LOOKUP;
         roll = $urandom_range(0, 99);
         if (roll < 55 && acl_used > 0) begin
            seed = acl_patterns[$urandom_range(0, acl_used - 1)];
            addr = $urandom();
            for (k = 0; k < 4; k++) begin
               if (seed[8*k +: 8] != 8'd0) addr[8*k +: 8] = seed[8*k +: 8];
            end
            if ($urandom_range(0, 4) == 0) begin
               bit_pos = $urandom_range(0, ADDR_W - 1);
               addr[bit_pos] = ~addr[bit_pos];
            end
         end else if (roll < 65) begin
            addr = FREE_MARK;
         end else if (roll < 70) begin
            addr = '0;
         end else begin
            addr = $urandom();
         end
      end
      offer(func, addr);
   endtask

   task automatic drain_results();
      while (requests_taken != requests_sent || verdicts_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_drop_on_match(input logic value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      acl_drop_on_match = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender: bursts of words separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin : sender
      maf_request_type word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (requests_waiting.size() > 0) begin
            word = requests_waiting.pop_front();
            req_tdata <= {6'b0, word.address, word.func};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : request_capture
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         verdicts_due.push_back(filter_predict(req_tdata[1:0], req_tdata[33:2]));
         requests_taken++;
      end
   end

   // Receiver: stall rate changes every so often, and one long hold-off lets the
   // block back up while the sender keeps offering words.
   int mode_left = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0, 1: stall_pct = 0;
               2:    stall_pct = 30;
               default: stall_pct = 70;
            endcase
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_checked >= 120) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      maf_result_type seen;
      maf_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.drop = rsp_tdata[0];
         seen.status = rsp_tdata[2:1];
         seen.entry_count = rsp_tdata[13:3];
         if (verdicts_due.size() == 0) begin
            $error("result word arrived with nothing outstanding");
            mismatch_count++;
         end else begin
            want = verdicts_due.pop_front();
            if (seen.drop !== want.drop) begin
               $error("drop: expected %0d, got %0d", want.drop, seen.drop);
               mismatch_count++;
            end
            if (seen.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, seen.status);
               mismatch_count++;
            end
            if (seen.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count, seen.entry_count);
               mismatch_count++;
            end
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** masked_address_filter_table: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      int free_slots;
      int fill_count;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, drop_on_match still at its reset value of one.
      offer(FUNC_LOOKUP, 32'hffff_ffff);
      offer(FUNC_REMOVE, 32'h0a00_0000);
      offer(FUNC_NONE,   32'h1234_5678);
      offer(FUNC_ADD,    32'h0a00_0000);
      offer(FUNC_ADD,    32'hc0a8_0101);
      offer(FUNC_ADD,    FREE_MARK);
      offer(FUNC_LOOKUP, 32'h0a01_0203);
      offer(FUNC_LOOKUP, 32'hc0a8_0102);
      offer(FUNC_LOOKUP, FREE_MARK);
      // The all-zero pattern takes the free slot and then matches anything.
      offer(FUNC_ADD,    32'h0000_0000);
      offer(FUNC_LOOKUP, 32'h0102_0304);
      offer(FUNC_REMOVE, 32'h0000_0000);
      offer(FUNC_ADD,    32'h0000_00ff);
      offer(FUNC_LOOKUP, 32'h0000_00ff);
      offer(FUNC_LOOKUP, 32'hffff_ff00);
      offer(FUNC_ADD,    FREE_MARK);
      offer(FUNC_REMOVE, FREE_MARK);
      offer(FUNC_REMOVE, 32'h0a00_0000);
      offer(FUNC_NONE,   32'hffff_ffff);
      drain_results();
      write_drop_on_match(1'b0);
      offer(FUNC_LOOKUP, 32'hc0a8_0101);
      offer(FUNC_LOOKUP, 32'h0000_0000);
      offer(FUNC_NONE,   32'h0000_0000);

      for (i = 0; i < 290; i++) offer_random_request();
      drain_results();
      write_drop_on_match(1'b1);
      for (i = 0; i < 290; i++) offer_random_request();
      drain_results();
      write_drop_on_match(1'b0);

      // Fill every entry so that a further add finds the table full.
      free_slots = 0;
      for (i = 0; i < acl_used; i++) begin
         if (acl_patterns[i] == FREE_MARK) free_slots++;
      end
      fill_count = TABLE_DEPTH - acl_used + free_slots;
      for (i = 0; i < fill_count; i++) begin
         offer(FUNC_ADD, {8'd11, 8'(i >> 8), 8'(i), 8'd7});
      end
      offer(FUNC_ADD,    32'h0b00_00ff);
      offer(FUNC_LOOKUP, 32'h0c00_0000);
      offer(FUNC_LOOKUP, FREE_MARK);
      drain_results();
      offer(FUNC_REMOVE, acl_patterns[TABLE_DEPTH-1]);
      offer(FUNC_ADD,    FREE_MARK);
      offer(FUNC_ADD,    32'h0d00_0000);
      offer(FUNC_ADD,    32'h0d00_0001);
      drain_results();
      offer(FUNC_REMOVE, acl_patterns[0]);
      offer(FUNC_LOOKUP, 32'h0d01_0203);
      drain_results();
      write_drop_on_match(1'b1);
      offer(FUNC_LOOKUP, 32'h0c00_0000);
      drain_results();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** masked_address_filter_table: PASSED **");
      end else begin
         $display("** masked_address_filter_table: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/maf_pkg.sv
design/maf_compare.sv
design/maf_engine.sv
design/masked_address_filter_table.sv
tb/sv/tb.sv
